FILE: rtl/fir_fc_pkg.sv
// package: shared types and constants of the full-convolution fir filter
package fir_fc_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int COEF_W        = 16;
    localparam int PROD_W        = SAMPLE_W + COEF_W;
    localparam int FRAC_BITS     = 14;
    localparam int ROUND_ADD     = 8192;
    localparam int NUM_COEF_REGS = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int OUT_MAX       = 32767;
    localparam int OUT_MIN       = -32768;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_4 = 3'd4;

    // reset values of the coefficient registers
    localparam logic signed [COEF_W-1:0] COEF_RST_0 = 16'sd1638;
    localparam logic signed [COEF_W-1:0] COEF_RST_1 = 16'sd1638;
    localparam logic signed [COEF_W-1:0] COEF_RST_2 = 16'sd3277;
    localparam logic signed [COEF_W-1:0] COEF_RST_3 = 16'sd3277;
    localparam logic signed [COEF_W-1:0] COEF_RST_4 = 16'sd6554;

    // one queued input word
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_item;

endpackage

FILE: rtl/fir_full_convolution.sv
// top level: full linear convolution fir filter with tail flush
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_sample, i_block_end
//  output    out        o_valid / i_stall    o_filtered, o_run_last, o_is_tail
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// one word per cycle sustained on ordinary samples while the output is not held; a word
// flagged block end occupies the back end for its own result plus TAPS-1 tail results
// an accepted word passes the queue write, the product register, then sum, round
// and saturate into the output register
// reset is synchronous, active low: clears the queue, delay line and tail counter,
// and loads the coefficient reset values
// a held output stalls the whole back end; the queue then fills and raises o_stall
module fir_full_convolution #(
    parameter int TAPS = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    // input words
    input  logic                 i_valid,
    input  logic signed [15:0]   i_sample,
    input  logic                 i_block_end,
    output logic                 o_stall,
    // result words
    output logic                 o_valid,
    output logic signed [15:0]   o_filtered,
    output logic                 o_run_last,
    output logic                 o_is_tail,
    input  logic                 i_stall
);

    // queue between front and back ends
    logic              w_q_valid;
    logic              w_q_pop;
    fir_fc_pkg::t_item w_q_item;

    // front: accept words, tag block end, buffer two deep
    fir_fc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_sample    (i_sample),
        .i_block_end (i_block_end),
        .o_stall     (o_stall),
        .o_q_valid   (w_q_valid),
        .o_q_item    (w_q_item),
        .i_q_pop     (w_q_pop)
    );

    // back: expand block end into tail, filter, round, saturate
    fir_fc_back #(
        .TAPS (TAPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_valid     (o_valid),
        .o_filtered  (o_filtered),
        .o_run_last  (o_run_last),
        .o_is_tail   (o_is_tail),
        .i_stall     (i_stall)
    );

endmodule

FILE: rtl/fir_fc_front.sv
// front end: accepts input words and holds them in a two-entry queue
module fir_fc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [15:0]   i_sample,
    input  logic                 i_block_end,
    output logic                 o_stall,
    output logic                 o_q_valid,
    output fir_fc_pkg::t_item    o_q_item,
    input  logic                 i_q_pop
);

    fir_fc_pkg::t_item r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic [1:0]        n_count;
    logic              w_push;
    logic              w_pop;

    assign o_stall   = (r_count == 2'd2);
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_mem[r_rd_ptr];
    assign w_push    = i_valid && !o_stall;
    assign w_pop     = i_q_pop && o_q_valid;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // classify: last flag travels with the sample
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr].sample <= i_sample;
            r_mem[r_wr_ptr].last   <= i_block_end;
        end
    end

endmodule

FILE: rtl/fir_fc_back.sv
// back end: tail sequencer, delay line, multiply and sum pipeline, output register
module fir_fc_back #(
    parameter int TAPS = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_q_valid,
    input  fir_fc_pkg::t_item    i_q_item,
    output logic                 o_q_pop,
    output logic                 o_valid,
    output logic signed [15:0]   o_filtered,
    output logic                 o_run_last,
    output logic                 o_is_tail,
    input  logic                 i_stall
);

    localparam int CNT_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W  = fir_fc_pkg::PROD_W + $clog2(TAPS) + 1;
    localparam int HIST_D = (TAPS > 1) ? TAPS - 1 : 1;

    logic signed [fir_fc_pkg::COEF_W-1:0]   r_coef [fir_fc_pkg::NUM_COEF_REGS];
    logic signed [fir_fc_pkg::COEF_W-1:0]   w_coef [TAPS];
    logic signed [fir_fc_pkg::SAMPLE_W-1:0] w_win  [TAPS];
    logic signed [fir_fc_pkg::SAMPLE_W-1:0] w_cur;
    logic [CNT_W-1:0]                       r_tail_cnt;
    logic                                   w_adv;
    logic                                   w_issue;
    logic                                   w_from_q;
    logic                                   w_run_last;
    logic                                   w_is_tail;

    logic signed [fir_fc_pkg::PROD_W-1:0]   r_prod [TAPS];
    logic                                   r_s1_valid;
    logic                                   r_s1_last;
    logic                                   r_s1_tail;

    logic signed [ACC_W-1:0]                w_acc;
    logic signed [ACC_W-1:0]                w_rnd;
    logic signed [ACC_W-1:0]                w_q;
    logic signed [fir_fc_pkg::SAMPLE_W-1:0] w_sat;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= fir_fc_pkg::COEF_RST_0;
            r_coef[1] <= fir_fc_pkg::COEF_RST_1;
            r_coef[2] <= fir_fc_pkg::COEF_RST_2;
            r_coef[3] <= fir_fc_pkg::COEF_RST_3;
            r_coef[4] <= fir_fc_pkg::COEF_RST_4;
        end else if (i_cfg_we && i_cfg_index <= fir_fc_pkg::REG_COEF_4) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    // taps without a register multiply by zero
    for (genvar k = 0; k < TAPS; k++) begin : g_coef
        if (k < fir_fc_pkg::NUM_COEF_REGS) begin : g_reg
            assign w_coef[k] = r_coef[k];
        end else begin : g_zero
            assign w_coef[k] = '0;
        end
    end

    // whole pipeline moves when the output register can take a word
    assign w_adv      = !o_valid || !i_stall;
    assign w_from_q   = (r_tail_cnt == '0) && i_q_valid;
    assign w_issue    = w_adv && ((r_tail_cnt != '0) || i_q_valid);
    assign o_q_pop    = w_adv && w_from_q;
    assign w_cur      = (r_tail_cnt != '0) ? '0 : i_q_item.sample;
    assign w_is_tail  = (r_tail_cnt != '0);
    assign w_run_last = (r_tail_cnt != '0) ? (r_tail_cnt == CNT_W'(1))
                                           : (!i_q_item.last || TAPS <= 1);

    // tail counter: loaded on a last sample, counts zero shifts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_cnt <= '0;
        end else if (w_issue) begin
            if (r_tail_cnt != '0) begin
                r_tail_cnt <= r_tail_cnt - CNT_W'(1);
            end else if (i_q_item.last && TAPS > 1) begin
                r_tail_cnt <= CNT_W'(TAPS - 1);
            end
        end
    end

    assign w_win[0] = w_cur;

    // delay line; the tail's zeros leave it cleared at block end
    if (TAPS > 1) begin : g_hist
        logic signed [fir_fc_pkg::SAMPLE_W-1:0] r_hist [HIST_D];

        for (genvar k = 1; k < TAPS; k++) begin : g_win
            assign w_win[k] = r_hist[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                for (int k = 0; k < HIST_D; k++) begin
                    r_hist[k] <= '0;
                end
            end else if (w_issue) begin
                r_hist[0] <= w_cur;
                for (int k = 1; k < HIST_D; k++) begin
                    r_hist[k] <= r_hist[k-1];
                end
            end
        end
    end

    // stage 1: one product per tap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_last <= w_run_last;
            r_s1_tail <= w_is_tail;
            for (int k = 0; k < TAPS; k++) begin
                r_prod[k] <= w_coef[k] * w_win[k];
            end
        end
    end

    // stage 2: sum, round to nearest, saturate
    always_comb begin
        w_acc = '0;
        for (int k = 0; k < TAPS; k++) begin
            w_acc = w_acc + ACC_W'(r_prod[k]);
        end
        w_rnd = w_acc + ACC_W'(fir_fc_pkg::ROUND_ADD);
        w_q   = w_rnd >>> fir_fc_pkg::FRAC_BITS;
        if (w_q > ACC_W'(fir_fc_pkg::OUT_MAX)) begin
            w_sat = fir_fc_pkg::SAMPLE_W'(fir_fc_pkg::OUT_MAX);
        end else if (w_q < ACC_W'(fir_fc_pkg::OUT_MIN)) begin
            w_sat = fir_fc_pkg::SAMPLE_W'(fir_fc_pkg::OUT_MIN);
        end else begin
            w_sat = w_q[fir_fc_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_filtered <= w_sat;
            o_run_last <= r_s1_last;
            o_is_tail  <= r_s1_tail;
        end
    end

endmodule
